### src/near_pair_merge_table_defines.svh
// Assertion helpers for the pair table checker.
`ifndef NEAR_PAIR_MERGE_TABLE_DEFINES_SVH
`define NEAR_PAIR_MERGE_TABLE_DEFINES_SVH

// Clocked check, off while reset is high.
`define NPMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define NPMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/npmt_pkg.sv
`default_nettype none
package npmt_pkg;

  localparam int CFG_W  = 12;
  localparam int RIDX_W = 5;
  localparam int ST_W   = 3;
  localparam int CNT_OUT_W = 6;
  localparam int REG_IDX_W = 2;

  localparam logic [ST_W-1:0] ST_IGNORED  = 3'd0;
  localparam logic [ST_W-1:0] ST_MERGED   = 3'd1;
  localparam logic [ST_W-1:0] ST_APPENDED = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_READ     = 3'd4;

  localparam logic [1:0] MODE_MAX    = 2'd0;
  localparam logic [1:0] MODE_MIN    = 2'd1;
  localparam logic [1:0] MODE_REPL   = 2'd2;
  localparam logic [1:0] MODE_MINMAX = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAP    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0] RADIUS_RESET = 12'd10;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              vld;
    logic              act;
    logic              ign;
    logic [RIDX_W-1:0] ridx;
  } ctl_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] radius;
  } cfg_t;

endpackage
`default_nettype wire

### src/npmt_cell.sv
`default_nettype none
module npmt_cell import npmt_pkg::*; #(
  parameter int VALUE_BITS = 12,
  parameter int CNT_W      = 6,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic [CNT_W-1:0]      held,
  input  wire logic                  app_we,
  input  wire logic [VALUE_BITS-1:0] app_a,
  input  wire logic [VALUE_BITS-1:0] app_b,
  input  wire ctl_t                  ctl_in,
  input  wire logic [VALUE_BITS-1:0] a_in,
  input  wire logic [VALUE_BITS-1:0] b_in,
  input  wire logic [CNT_W-1:0]      cnt_in,
  input  wire logic [VALUE_BITS-1:0] rf_in,
  input  wire logic [VALUE_BITS-1:0] rs_in,
  output ctl_t                       ctl_out,
  output logic [VALUE_BITS-1:0]      a_out,
  output logic [VALUE_BITS-1:0]      b_out,
  output logic [CNT_W-1:0]           cnt_out,
  output logic [VALUE_BITS-1:0]      rf_out,
  output logic [VALUE_BITS-1:0]      rs_out
);

  localparam int DW = (VALUE_BITS > CFG_W) ? VALUE_BITS : CFG_W;
  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);
  localparam logic [31:0] IDX32 = 32'(INDEX);

  logic [VALUE_BITS-1:0] first;
  logic [VALUE_BITS-1:0] second;
  logic [VALUE_BITS-1:0] first_next;
  logic [VALUE_BITS-1:0] second_next;
  logic [VALUE_BITS-1:0] da;
  logic [VALUE_BITS-1:0] db;
  logic held_ok;
  logic match;
  logic hit;
  logic rd_hit;

  assign da = (a_in >= first) ? (a_in - first) : (first - a_in);
  assign db = (b_in >= second) ? (b_in - second) : (second - b_in);
  assign held_ok = IDX < held;
  assign match = (DW'(da) <= DW'(cfg.radius)) && (DW'(db) <= DW'(cfg.radius));
  assign hit = ctl_in.vld && (ctl_in.act == ACT_PUSH) && !ctl_in.ign && held_ok && match;
  assign rd_hit = ctl_in.vld && (ctl_in.act == ACT_READ) && held_ok &&
                  ({{(32-RIDX_W){1'b0}}, ctl_in.ridx} == IDX32);

  always_comb begin
    case (cfg.mode)
      MODE_MAX: begin
        first_next  = (a_in > first) ? a_in : first;
        second_next = (b_in > second) ? b_in : second;
      end
      MODE_MIN: begin
        first_next  = (a_in < first) ? a_in : first;
        second_next = (b_in < second) ? b_in : second;
      end
      MODE_REPL: begin
        first_next  = a_in;
        second_next = b_in;
      end
      default: begin
        first_next  = (a_in < first) ? a_in : first;
        second_next = (b_in > second) ? b_in : second;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    a_out   <= a_in;
    b_out   <= b_in;
    cnt_out <= cnt_in + CNT_W'(hit);
    rf_out  <= rd_hit ? first : rf_in;
    rs_out  <= rd_hit ? second : rs_in;
  end

  always_ff @(posedge clk) begin
    if (app_we && (held == IDX)) begin
      first  <= app_a;
      second <= app_b;
    end else if (hit) begin
      first  <= first_next;
      second <= second_next;
    end
  end

endmodule
`default_nettype wire

### src/near_pair_merge_table.sv
// A result shows on out_valid once its transaction has walked the chain of TABLE_DEPTH
// cells one cell per cycle, waited in the pending register and retired; retiring also
// writes an appended pair. Only one transaction walks the table at a time.
// in_ready returns while the result still waits on out_ready.
// Reset clears the entry count, the pipeline and the output, and loads register
// defaults (mode 0, gap 0, radius 10); stored pairs are not cleared.
`default_nettype none
module near_pair_merge_table import npmt_pkg::*; #(
  parameter int TABLE_DEPTH = 32,
  parameter int VALUE_BITS  = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  action,
  input  wire logic [VALUE_BITS-1:0] first_value,
  input  wire logic [VALUE_BITS-1:0] second_value,
  input  wire logic [RIDX_W-1:0]     read_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ST_W-1:0]            status,
  output logic [CNT_OUT_W-1:0]       match_count,
  output logic [CNT_OUT_W-1:0]       entry_count,
  output logic [VALUE_BITS-1:0]      read_first,
  output logic [VALUE_BITS-1:0]      read_second
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DW = (VALUE_BITS > CFG_W) ? VALUE_BITS : CFG_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [1:0]       mode;
  logic [CFG_W-1:0] gap;
  logic [CFG_W-1:0] radius;
  cfg_t             cfg;

  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic             busy;
  logic             accept;
  logic [VALUE_BITS-1:0] pair_diff;

  ctl_t                  ctl [0:TABLE_DEPTH];
  logic [VALUE_BITS-1:0] ta  [0:TABLE_DEPTH];
  logic [VALUE_BITS-1:0] tb  [0:TABLE_DEPTH];
  logic [CNT_W-1:0]      tcnt[0:TABLE_DEPTH];
  logic [VALUE_BITS-1:0] trf [0:TABLE_DEPTH];
  logic [VALUE_BITS-1:0] trs [0:TABLE_DEPTH];

  logic                  pend;
  logic                  pend_act;
  logic                  pend_ign;
  logic [VALUE_BITS-1:0] pend_a;
  logic [VALUE_BITS-1:0] pend_b;
  logic [CNT_W-1:0]      pend_cnt;
  logic [VALUE_BITS-1:0] pend_rf;
  logic [VALUE_BITS-1:0] pend_rs;

  logic            out_free;
  logic            retire;
  logic            app_we;
  logic [ST_W-1:0] status_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy;
  assign cfg.mode   = mode;
  assign cfg.radius = radius;

  assign pair_diff = (first_value >= second_value) ? (first_value - second_value)
                                                   : (second_value - first_value);

  always_comb begin
    ctl[0].vld  = accept;
    ctl[0].act  = action;
    ctl[0].ign  = DW'(pair_diff) <= DW'(gap);
    ctl[0].ridx = read_index;
  end
  assign ta[0]   = first_value;
  assign tb[0]   = second_value;
  assign tcnt[0] = '0;
  assign trf[0]  = '0;
  assign trs[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    npmt_cell #(
      .VALUE_BITS(VALUE_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cfg    (cfg),
      .held   (held),
      .app_we (app_we),
      .app_a  (pend_a),
      .app_b  (pend_b),
      .ctl_in (ctl[i]),
      .a_in   (ta[i]),
      .b_in   (tb[i]),
      .cnt_in (tcnt[i]),
      .rf_in  (trf[i]),
      .rs_in  (trs[i]),
      .ctl_out(ctl[i+1]),
      .a_out  (ta[i+1]),
      .b_out  (tb[i+1]),
      .cnt_out(tcnt[i+1]),
      .rf_out (trf[i+1]),
      .rs_out (trs[i+1])
    );
  end

  assign out_free = !out_valid || out_ready;
  assign retire   = pend && out_free;

  always_comb begin
    app_we    = 1'b0;
    held_next = held;
    if (pend_act == ACT_READ) begin
      status_next = ST_READ;
    end else if (pend_ign) begin
      status_next = ST_IGNORED;
    end else if (pend_cnt != '0) begin
      status_next = ST_MERGED;
    end else if (held < DEPTH_C) begin
      status_next = ST_APPENDED;
      app_we      = retire;
      held_next   = held + CNT_W'(1);
    end else begin
      status_next = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_MAX;
      gap    <= '0;
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode   <= cfg_data[1:0];
        REG_GAP:    gap    <= cfg_data;
        REG_RADIUS: radius <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      held      <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (retire) begin
        busy <= 1'b0;
      end
      if (ctl[TABLE_DEPTH].vld) begin
        pend <= 1'b1;
      end else if (retire) begin
        pend <= 1'b0;
      end
      if (retire) begin
        out_valid <= 1'b1;
        held      <= held_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl[TABLE_DEPTH].vld) begin
      pend_act <= ctl[TABLE_DEPTH].act;
      pend_ign <= ctl[TABLE_DEPTH].ign;
      pend_a   <= ta[TABLE_DEPTH];
      pend_b   <= tb[TABLE_DEPTH];
      pend_cnt <= tcnt[TABLE_DEPTH];
      pend_rf  <= trf[TABLE_DEPTH];
      pend_rs  <= trs[TABLE_DEPTH];
    end
    if (retire) begin
      status      <= status_next;
      match_count <= CNT_OUT_W'(pend_cnt);
      entry_count <= CNT_OUT_W'(held_next);
      read_first  <= pend_rf;
      read_second <= pend_rs;
    end
  end

endmodule
`default_nettype wire

### src/npmt_checker.sv
`default_nettype none
`include "near_pair_merge_table_defines.svh"
module npmt_checker import npmt_pkg::*; #(
  parameter int VALUE_BITS = 12
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [ST_W-1:0]       status,
  input wire logic [CNT_OUT_W-1:0]  match_count,
  input wire logic [CNT_OUT_W-1:0]  entry_count,
  input wire logic [VALUE_BITS-1:0] read_first,
  input wire logic [VALUE_BITS-1:0] read_second
);

  // one transaction in flight
  `NPMT_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "second transaction taken while busy")

  `NPMT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(entry_count)), "result changed while stalled")

  `NPMT_ASSERT(a_read_no_match, (out_valid && status == ST_READ) |-> (match_count == '0), "match count on a read")

  `NPMT_ASSERT(a_push_no_data, (out_valid && status != ST_READ) |-> (read_first == '0 && read_second == '0), "read data on a push")

  `NPMT_ASSERT_ALWAYS(a_merge_count, (out_valid && !rst && status == ST_MERGED) |-> (match_count != '0 && entry_count != '0), "merge without a matched entry")

endmodule

bind near_pair_merge_table npmt_checker #(.VALUE_BITS(VALUE_BITS)) u_npmt_checker (.*);
`default_nettype wire
